@@ design/vaso_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared types, codes and constants for the oldest-steal voice allocator.
// ----------------------------------------------------------------------------
package vaso_pkg;

    // Defaults and fixed limits
    localparam int VOICES_DEF   = 8;
    localparam int LOADED_SLOTS = 16;
    localparam int SAMPLE_LIMIT = (LOADED_SLOTS < 16) ? LOADED_SLOTS : 16;
    localparam int MAX_RESULTS  = 8;

    localparam logic [23:0] STEP_BYTES = 24'd2;
    localparam logic [23:0] POS_MAX    = 24'hFF_FFFF;

    // Request commands
    typedef enum logic [1:0] {
        CMD_PLAY     = 2'd0,
        CMD_STOP     = 2'd1,
        CMD_STOP_ALL = 2'd2,
        CMD_TICK     = 2'd3
    } t_cmd;

    // Result kinds
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // End reasons
    localparam logic [1:0] REASON_PRUNED   = 2'd0;
    localparam logic [1:0] REASON_STOPPED  = 2'd1;
    localparam logic [1:0] REASON_FINISHED = 2'd2;

    // One voice slot as stored
    typedef struct packed {
        logic        active;
        logic [30:0] handle;
        logic [23:0] pos;
        logic [23:0] len;
    } t_voice_entry;

    // One result
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  voice;
        logic [30:0] handle;
        logic [1:0]  reason;
    } t_result;

endpackage

@@ design/vaso_voice_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice slot store
// Per-voice state with one shared read/write index; active bits clear on reset.
// ----------------------------------------------------------------------------
module vaso_voice_store
    import vaso_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    localparam int IDX_W = $clog2(VOICES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic               i_we,
    input  t_voice_entry       i_wdata,
    output t_voice_entry       o_rdata
);

    logic [VOICES-1:0] r_active;
    logic [30:0]       r_handle [VOICES];
    logic [23:0]       r_pos    [VOICES];
    logic [23:0]       r_len    [VOICES];

    // Active flags: only these need a known value after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_we) begin
            r_active[i_idx] <= i_wdata.active;
        end
    end

    // Slot payload
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_handle[i_idx] <= i_wdata.handle;
            r_pos[i_idx]    <= i_wdata.pos;
            r_len[i_idx]    <= i_wdata.len;
        end
    end

    // Read at the sequencer's current slot
    always_comb begin
        o_rdata.active = r_active[i_idx];
        o_rdata.handle = r_handle[i_idx];
        o_rdata.pos    = r_pos[i_idx];
        o_rdata.len    = r_len[i_idx];
    end

endmodule

@@ design/voice_allocator_steal_oldest_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator with oldest-voice stealing
// Allocates, stops and ages playback voices, one slot visited per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   A request (i_command with its fields) is taken on a clock edge where
//   i_start is high and o_busy is low. o_busy then stays high until the
//   request's last result has been presented.
//   Results come out one per cycle at most, each valid for exactly one cycle
//   with o_strobe high; o_last marks the final result of a request. The
//   receiver cannot stall the block, so results must be taken as they come.
//   The sequencer visits one voice slot per cycle through a single compare /
//   saturating-add unit. o_busy stays high for the shortest time on a rejected
//   play or a stop hitting slot 0 and for the longest on a play that steals;
//   stop-all and tick scan every slot.
//   The last result shows in the first idle cycle, and the next request can
//   already be taken in that cycle.
//   i_cfg_we / i_cfg_wdata write the loaded-sample mask; write it only while
//   the block is idle. Synchronous active-low reset clears all voices, the
//   handle counter and the mask.
// ----------------------------------------------------------------------------
module voice_allocator_steal_oldest_top
    import vaso_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_sample_id,
    input  logic [30:0] i_handle,
    input  logic [23:0] i_sample_length,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // result channel
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_voice,
    output logic [30:0] o_handle_out,
    output logic [1:0]  o_reason,
    output logic        o_last
);

    localparam int IDX_W = $clog2(VOICES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_STEAL,
        S_ALLOC,
        S_FINISH
    } t_state;

    t_state       r_state, n_state;
    t_cmd         r_cmd, n_cmd;
    logic [7:0]   r_sid, n_sid;
    logic [30:0]  r_h, n_h;
    logic [23:0]  r_len, n_len;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_best, n_best;
    logic [23:0]  r_best_pos, n_best_pos;
    logic         r_have_best, n_have_best;
    logic [30:0]  r_hcnt, n_hcnt;
    logic         r_pend_v, n_pend_v;
    t_result      r_pend, n_pend;
    logic [3:0]   r_nres, n_nres;
    logic [15:0]  r_mask, n_mask;
    logic         r_strobe, n_strobe;
    t_result      r_out, n_out;
    logic         r_last, n_last;

    t_voice_entry rd, wd;
    logic         we;

    logic         produce;
    t_result      res;
    logic         last_idx;
    logic [24:0]  pos_inc;
    logic [23:0]  new_pos;
    logic         pos_ended;
    logic         better;
    logic         sid_ok;
    logic [30:0]  hnext;

    vaso_voice_store #(
        .VOICES (VOICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_idx),
        .i_we    (we),
        .i_wdata (wd),
        .o_rdata (rd)
    );

    // Shared slot unit: saturating advance, length compare, age compare
    always_comb begin
        last_idx  = (r_idx == LAST_IDX);
        pos_inc   = {1'b0, rd.pos} + {1'b0, STEP_BYTES};
        new_pos   = pos_inc[24] ? POS_MAX : pos_inc[23:0];
        pos_ended = (new_pos >= rd.len);
        better    = (rd.pos > r_best_pos);
        sid_ok    = (r_sid < 8'(SAMPLE_LIMIT)) && r_mask[r_sid[3:0]];
        hnext     = r_hcnt + 31'd1;
        if (hnext == 31'd0) begin
            hnext = 31'd1;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_sid       = r_sid;
        n_h         = r_h;
        n_len       = r_len;
        n_idx       = r_idx;
        n_best      = r_best;
        n_best_pos  = r_best_pos;
        n_have_best = r_have_best;
        n_hcnt      = r_hcnt;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        n_nres      = r_nres;
        n_mask      = r_mask;
        n_strobe    = 1'b0;
        n_out       = r_out;
        n_last      = 1'b0;
        we          = 1'b0;
        wd          = rd;
        produce     = 1'b0;
        res         = '0;

        // mask write takes effect on any enabled edge
        if (i_cfg_we) begin
            n_mask = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd       = t_cmd'(i_command);
                    n_sid       = i_sample_id;
                    n_h         = i_handle;
                    n_len       = i_sample_length;
                    n_idx       = '0;
                    n_best      = '0;
                    n_best_pos  = '0;
                    n_have_best = 1'b0;
                    n_pend_v    = 1'b0;
                    n_nres      = '0;
                    n_state     = (t_cmd'(i_command) == CMD_PLAY) ? S_CHECK : S_SCAN;
                end
            end

            // sample must be loaded and in range
            S_CHECK: begin
                if (sid_ok) begin
                    n_state = S_SCAN;
                end else begin
                    produce    = 1'b1;
                    res.kind   = KIND_REJECT;
                    n_state    = S_FINISH;
                end
            end

            S_SCAN: begin
                case (r_cmd)
                    CMD_PLAY: begin
                        if (!rd.active) begin
                            n_state = S_ALLOC;
                        end else begin
                            if (better) begin
                                n_best_pos  = rd.pos;
                                n_best      = r_idx;
                                n_have_best = 1'b1;
                            end
                            if (last_idx) begin
                                if (r_have_best || better) begin
                                    n_idx   = better ? r_idx : r_best;
                                    n_state = S_STEAL;
                                end else begin
                                    // every slot busy and none has moved
                                    produce  = 1'b1;
                                    res.kind = KIND_REJECT;
                                    n_state  = S_FINISH;
                                end
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                    end

                    CMD_STOP: begin
                        if (rd.active && (rd.handle == r_h)) begin
                            produce    = 1'b1;
                            res.kind   = KIND_END;
                            res.voice  = 3'(r_idx);
                            res.handle = rd.handle;
                            res.reason = REASON_STOPPED;
                            we         = 1'b1;
                            wd         = '0;
                            n_state    = S_FINISH;
                        end else if (last_idx) begin
                            n_state = S_FINISH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end

                    CMD_STOP_ALL: begin
                        if (rd.active) begin
                            produce    = 1'b1;
                            res.kind   = KIND_END;
                            res.voice  = 3'(r_idx);
                            res.handle = rd.handle;
                            res.reason = REASON_STOPPED;
                            we         = 1'b1;
                            wd         = '0;
                        end
                        if (last_idx) begin
                            n_state = S_FINISH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end

                    CMD_TICK: begin
                        if (rd.active) begin
                            we     = 1'b1;
                            wd.pos = new_pos;
                            if (pos_ended) begin
                                produce    = 1'b1;
                                res.kind   = KIND_END;
                                res.voice  = 3'(r_idx);
                                res.handle = rd.handle;
                                res.reason = REASON_FINISHED;
                                wd         = '0;
                            end
                        end
                        if (last_idx) begin
                            n_state = S_FINISH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end

                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end

            // prune the chosen voice before reuse
            S_STEAL: begin
                produce    = 1'b1;
                res.kind   = KIND_END;
                res.voice  = 3'(r_idx);
                res.handle = rd.handle;
                res.reason = REASON_PRUNED;
                we         = 1'b1;
                wd         = '0;
                n_state    = S_ALLOC;
            end

            // claim the slot with a fresh handle
            S_ALLOC: begin
                n_hcnt     = hnext;
                we         = 1'b1;
                wd.active  = 1'b1;
                wd.handle  = hnext;
                wd.pos     = '0;
                wd.len     = r_len;
                produce    = 1'b1;
                res.kind   = KIND_ACCEPT;
                res.voice  = 3'(r_idx);
                res.handle = hnext;
                n_state    = S_FINISH;
            end

            // flush the held result, or a none result if nothing is held, as the last one
            S_FINISH: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                if (r_pend_v) begin
                    n_out = r_pend;
                end else begin
                    n_out      = '0;
                    n_out.kind = KIND_NONE;
                end
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // one result is held back so the final one can carry the last flag
        if (produce && (r_nres < 4'(MAX_RESULTS))) begin
            n_nres = r_nres + 4'd1;
            if (r_pend_v) begin
                n_strobe = 1'b1;
                n_out    = r_pend;
                n_last   = 1'b0;
            end
            n_pend   = res;
            n_pend_v = 1'b1;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        r_sid      <= n_sid;
        r_h        <= n_h;
        r_len      <= n_len;
        r_best     <= n_best;
        r_best_pos <= n_best_pos;
        r_pend     <= n_pend;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= CMD_PLAY;
            r_idx       <= '0;
            r_have_best <= 1'b0;
            r_hcnt      <= '0;
            r_pend_v    <= 1'b0;
            r_nres      <= '0;
            r_mask      <= '0;
            r_strobe    <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_idx       <= n_idx;
            r_have_best <= n_have_best;
            r_hcnt      <= n_hcnt;
            r_pend_v    <= n_pend_v;
            r_nres      <= n_nres;
            r_mask      <= n_mask;
            r_strobe    <= n_strobe;
            r_last      <= n_last;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_kind       = r_out.kind;
    assign o_voice      = r_out.voice;
    assign o_handle_out = r_out.handle;
    assign o_reason     = r_out.reason;
    assign o_last       = r_last;

    // Assertions
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> (o_strobe && o_last))
        else $error("request finished without a last result");

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last flag without strobe");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request taken but block not busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> o_busy)
        else $error("non-final result while idle");

    a_handle_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == KIND_ACCEPT)) |-> (o_handle_out != 31'd0))
        else $error("accepted play given handle zero");

endmodule
